FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cond at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that ante implies cons in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sellm_pkg.sv
// ----------------------------------------------------------------------------
// Sellmeier index package
// Widths, register indexes, status codes and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package sellm_pkg;

  localparam int WAVE_W    = 24;
  localparam int COEF_W    = 32;
  localparam int INDEX_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_ONE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_TWO = 3'd6;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_POLE  = 2'd2;
  localparam status_t ST_NEG   = 2'd3;

  // squared wavelength in um^2, 2^-32 units
  localparam int WW_W       = 2 * WAVE_W;
  localparam int L2_W       = 45;
  localparam int LD_REM_W   = 14;
  localparam logic [LD_REM_W:0] LD_DIVISOR = 15'd15625;
  localparam int LD_STEPS   = 5;
  localparam int LD_STAGES  = L2_W / LD_STEPS;

  // squared pole and denominator
  localparam int PSQ_W      = 47;
  localparam int DEN_W      = 47;

  // oscillator term division
  localparam int NUM_W      = COEF_W + L2_W - 1;
  localparam int DIV_BITS   = 62;
  localparam int DIV_LAT    = DIV_BITS + 2;
  localparam int TERM_W     = DIV_BITS + 1;
  localparam logic [DIV_BITS-1:0] TERM_CAP = {2'b10, {(DIV_BITS-2){1'b0}}};

  // square root
  localparam int ROOT_W     = INDEX_W;
  localparam int SQ_LAT     = ROOT_W;
  localparam int SUM_W      = 64;
  localparam logic [SUM_W-1:0] ONE_Q24 = 64'd16777216;

endpackage

`default_nettype wire

FILE: rtl/core/sellm_div.sv
// ----------------------------------------------------------------------------
// Sellmeier term divider
// Pipelined restoring divide, one quotient bit per stage, saturated and signed.
// ----------------------------------------------------------------------------
`default_nettype none

module sellm_div
  import sellm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [NUM_W-1:0]         num,
  input  wire logic [DEN_W-1:0]         den,
  input  wire logic                     neg,
  output logic signed [TERM_W-1:0]      term
);

  logic [DEN_W-1:0]    s_rem [0:DIV_BITS];
  logic [DIV_BITS-1:0] s_qn  [0:DIV_BITS];
  logic [DEN_W-1:0]    s_den [0:DIV_BITS];
  logic                s_ovf [0:DIV_BITS];
  logic                s_neg [0:DIV_BITS];

  logic [DIV_BITS-1:0] q_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0] <= {{(DEN_W-(NUM_W-DIV_BITS)){1'b0}}, num[NUM_W-1:DIV_BITS]};
      s_qn[0]  <= num[DIV_BITS-1:0];
      s_den[0] <= den;
      s_ovf[0] <= {{(DEN_W-(NUM_W-DIV_BITS)){1'b0}}, num[NUM_W-1:DIV_BITS]} >= den;
      s_neg[0] <= neg;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [DEN_W:0] cur;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      cur  = {s_rem[k], s_qn[k][DIV_BITS-1]};
      diff = cur - {1'b0, s_den[k]};
      ge   = cur >= {1'b0, s_den[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        s_qn[k+1]  <= {s_qn[k][DIV_BITS-2:0], ge};
        s_den[k+1] <= s_den[k];
        s_ovf[k+1] <= s_ovf[k];
        s_neg[k+1] <= s_neg[k];
      end
    end
  end

  assign q_mag = (s_ovf[DIV_BITS] || s_qn[DIV_BITS] > TERM_CAP) ? TERM_CAP
                                                                 : s_qn[DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      term <= s_neg[DIV_BITS] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sellm_sqrt.sv
// ----------------------------------------------------------------------------
// Sellmeier square root
// Pipelined digit-by-digit integer root of {rad_hi, 32'b0}, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sellm_sqrt
  import sellm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [ROOT_W-1:0] rad_hi,
  output logic      [ROOT_W-1:0] root
);

  logic [ROOT_W+1:0] s_rem  [0:SQ_LAT];
  logic [ROOT_W-1:0] s_root [0:SQ_LAT];
  logic [ROOT_W-1:0] s_x    [0:SQ_LAT];

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_x[0]    = rad_hi;

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_step
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    always_comb begin
      cur   = {s_rem[k], s_x[k][ROOT_W-1:ROOT_W-2]};
      trial = {2'b00, s_root[k], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1]  <= ge ? (cur[ROOT_W+1:0] - trial[ROOT_W+1:0]) : cur[ROOT_W+1:0];
        s_root[k+1] <= {s_root[k][ROOT_W-2:0], ge};
        s_x[k+1]    <= {s_x[k][ROOT_W-3:0], 2'b00};
      end
    end
  end

  assign root = s_root[SQ_LAT];

endmodule

`default_nettype wire

FILE: rtl/core/sellmeier2_refractive_index.sv
// ----------------------------------------------------------------------------
// Sellmeier 2 refractive index
// Wavelength in, refractive index out, through a fixed-point deep pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel wavelength_valid/ready carries one Q16.8 wavelength item.
//   Result channel result_valid/ready carries index_value (Q4.28) and status.
//   Registers must be written through cfg_we/cfg_index/cfg_data while idle;
//   the user must keep to this, as the block itself does not enforce it.
// Throughput: one item per cycle unless stalled; every stage is a register
//   with a valid bit. Depth: two 62-stage term dividers and a 32-stage root.
// Stall: while a result waits and result_ready is low, the whole pipeline
//   holds and wavelength_ready drops; nothing is lost or repeated.
// Reset: rst clears all valid bits and loads the register reset values;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sellmeier2_refractive_index
  import sellm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  input  wire logic                 wavelength_valid,
  output logic                      wavelength_ready,
  input  wire logic [WAVE_W-1:0]    wavelength_nm,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output logic [INDEX_W-1:0]        index_value,
  output status_t                   status
);

  logic [WAVE_W-1:0] wave_min, wave_max;
  logic [COEF_W-1:0] coef_a, coef_b1, coef_b2, pole_one, pole_two;
  logic [PSQ_W-1:0]  psq1, psq2;
  logic [COEF_W-1:0] pm1, pm2, bm1, bm2;
  logic [2*COEF_W-1:0] psq1_full, psq2_full;
  logic              adv;

  assign adv = !result_valid || result_ready;
  assign wavelength_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_min <= '0;
      wave_max <= '1;
      coef_a   <= '0;
      coef_b1  <= '0;
      coef_b2  <= '0;
      pole_one <= '0;
      pole_two <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_MIN: wave_min <= cfg_data[WAVE_W-1:0];
        REG_WAVE_MAX: wave_max <= cfg_data[WAVE_W-1:0];
        REG_COEF_A:   coef_a   <= cfg_data;
        REG_COEF_B1:  coef_b1  <= cfg_data;
        REG_COEF_B2:  coef_b2  <= cfg_data;
        REG_POLE_ONE: pole_one <= cfg_data;
        REG_POLE_TWO: pole_two <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pm1 = pole_one[COEF_W-1] ? -pole_one : pole_one;
  assign pm2 = pole_two[COEF_W-1] ? -pole_two : pole_two;
  assign bm1 = coef_b1[COEF_W-1] ? -coef_b1 : coef_b1;
  assign bm2 = coef_b2[COEF_W-1] ? -coef_b2 : coef_b2;
  assign psq1_full = pm1 * pm1;
  assign psq2_full = pm2 * pm2;

  // squared poles follow the registers in the next cycle
  always_ff @(posedge clk) begin
    psq1 <= psq1_full[PSQ_W+15:16];
    psq2 <= psq2_full[PSQ_W+15:16];
  end

  // accept stage
  logic              a_v;
  logic [WAVE_W-1:0] a_w;
  status_t           a_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= wavelength_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_w  <= wavelength_nm;
      a_st <= (wavelength_nm < wave_min || wavelength_nm > wave_max) ? ST_RANGE : ST_OK;
    end
  end

  // square stage
  logic            b_v;
  logic [WW_W-1:0] b_ww;
  status_t         b_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ww <= a_w * a_w;
      b_st <= a_st;
    end
  end

  // divide by 15625, five quotient bits per stage
  logic                ld_v   [0:LD_STAGES];
  status_t             ld_st  [0:LD_STAGES];
  logic [LD_REM_W-1:0] ld_rem [0:LD_STAGES];
  logic [L2_W-1:0]     ld_qn  [0:LD_STAGES];

  assign ld_v[0]   = b_v;
  assign ld_st[0]  = b_st;
  assign ld_rem[0] = {1'b0, b_ww[WW_W-1:L2_W-10]};
  assign ld_qn[0]  = {b_ww[L2_W-11:0], 10'b0};

  for (genvar s = 0; s < LD_STAGES; s++) begin : g_ld
    logic [LD_REM_W-1:0] rem_n;
    logic [L2_W-1:0]     qn_n;
    logic [LD_REM_W:0]   cur;
    logic                ge;

    always_comb begin
      rem_n = ld_rem[s];
      qn_n  = ld_qn[s];
      cur   = '0;
      ge    = 1'b0;
      for (int i = 0; i < LD_STEPS; i++) begin
        cur   = {rem_n, qn_n[L2_W-1]};
        ge    = cur >= LD_DIVISOR;
        rem_n = ge ? LD_REM_W'(cur - LD_DIVISOR) : cur[LD_REM_W-1:0];
        qn_n  = {qn_n[L2_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ld_v[s+1] <= 1'b0;
      end else if (adv) begin
        ld_v[s+1] <= ld_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ld_st[s+1]  <= ld_st[s];
        ld_rem[s+1] <= rem_n;
        ld_qn[s+1]  <= qn_n;
      end
    end
  end

  // denominator stage
  logic [L2_W+2:0] dif1, dif2;
  logic            d_v, d_n1, d_n2;
  status_t         d_st;
  logic [L2_W-1:0] d_l2;
  logic [DEN_W-1:0] d_m1, d_m2;
  logic [L2_W+2:0] ndif1, ndif2;

  assign dif1  = {3'b000, ld_qn[LD_STAGES]} - {1'b0, psq1};
  assign dif2  = {3'b000, ld_qn[LD_STAGES]} - {1'b0, psq2};
  assign ndif1 = -dif1;
  assign ndif2 = -dif2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= ld_v[LD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_l2 <= ld_qn[LD_STAGES];
      d_m1 <= dif1[L2_W+2] ? ndif1[DEN_W-1:0] : dif1[DEN_W-1:0];
      d_m2 <= dif2[L2_W+2] ? ndif2[DEN_W-1:0] : dif2[DEN_W-1:0];
      d_n1 <= dif1[L2_W+2] ^ coef_b1[COEF_W-1];
      d_n2 <= dif2[L2_W+2] ^ coef_b2[COEF_W-1];
      if (ld_st[LD_STAGES] == ST_OK && (dif1 == '0 || dif2 == '0)) begin
        d_st <= ST_POLE;
      end else begin
        d_st <= ld_st[LD_STAGES];
      end
    end
  end

  // multiply stage, split across the low 32 and high 13 bits of L2
  logic                      e_v, e_n1, e_n2;
  status_t                   e_st;
  logic [DEN_W-1:0]          e_m1, e_m2;
  logic [2*COEF_W-1:0]       e_plo1, e_plo2;
  logic [COEF_W+L2_W-33:0]   e_phi1, e_phi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_st   <= d_st;
      e_m1   <= d_m1;
      e_m2   <= d_m2;
      e_n1   <= d_n1;
      e_n2   <= d_n2;
      e_plo1 <= bm1 * d_l2[31:0];
      e_plo2 <= bm2 * d_l2[31:0];
      e_phi1 <= bm1 * d_l2[L2_W-1:32];
      e_phi2 <= bm2 * d_l2[L2_W-1:32];
    end
  end

  // product assembly stage
  logic               f_v, f_n1, f_n2;
  status_t            f_st;
  logic [DEN_W-1:0]   f_m1, f_m2;
  logic [NUM_W-1:0]   f_num1, f_num2;
  logic [NUM_W:0]     sum1, sum2;

  assign sum1 = {e_phi1, 32'b0} + {{(NUM_W+1-2*COEF_W){1'b0}}, e_plo1};
  assign sum2 = {e_phi2, 32'b0} + {{(NUM_W+1-2*COEF_W){1'b0}}, e_plo2};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_st   <= e_st;
      f_m1   <= e_m1;
      f_m2   <= e_m2;
      f_n1   <= e_n1;
      f_n2   <= e_n2;
      f_num1 <= sum1[NUM_W-1:0];
      f_num2 <= sum2[NUM_W-1:0];
    end
  end

  logic signed [TERM_W-1:0] term1, term2;

  sellm_div u_div1 (
    .clk  (clk),
    .en   (adv),
    .num  (f_num1),
    .den  (f_m1),
    .neg  (f_n1),
    .term (term1)
  );

  sellm_div u_div2 (
    .clk  (clk),
    .en   (adv),
    .num  (f_num2),
    .den  (f_m2),
    .neg  (f_n2),
    .term (term2)
  );

  logic    g_v  [1:DIV_LAT];
  status_t g_st [1:DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DIV_LAT; i++) g_v[i] <= 1'b0;
    end else if (adv) begin
      g_v[1] <= f_v;
      for (int i = 2; i <= DIV_LAT; i++) g_v[i] <= g_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_st[1] <= f_st;
      for (int i = 2; i <= DIV_LAT; i++) g_st[i] <= g_st[i-1];
    end
  end

  // radicand stage
  logic [SUM_W-1:0]  rsum;
  logic              h_v, h_big;
  status_t           h_st;
  logic [ROOT_W-1:0] h_rad;

  assign rsum = {{(SUM_W-COEF_W){coef_a[COEF_W-1]}}, coef_a}
              + {{(SUM_W-TERM_W){term1[TERM_W-1]}}, term1}
              + {{(SUM_W-TERM_W){term2[TERM_W-1]}}, term2}
              + ONE_Q24;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (adv) begin
      h_v <= g_v[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_rad <= rsum[ROOT_W-1:0];
      h_big <= !rsum[SUM_W-1] && (rsum[SUM_W-2:ROOT_W] != '0);
      if (g_st[DIV_LAT] == ST_OK && rsum[SUM_W-1]) begin
        h_st <= ST_NEG;
      end else begin
        h_st <= g_st[DIV_LAT];
      end
    end
  end

  logic [ROOT_W-1:0] root;

  sellm_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_hi (h_rad),
    .root   (root)
  );

  logic    q_v   [1:SQ_LAT];
  logic    q_big [1:SQ_LAT];
  status_t q_st  [1:SQ_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SQ_LAT; i++) q_v[i] <= 1'b0;
    end else if (adv) begin
      q_v[1] <= h_v;
      for (int i = 2; i <= SQ_LAT; i++) q_v[i] <= q_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_big[1] <= h_big;
      q_st[1]  <= h_st;
      for (int i = 2; i <= SQ_LAT; i++) begin
        q_big[i] <= q_big[i-1];
        q_st[i]  <= q_st[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= q_v[SQ_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= q_st[SQ_LAT];
      if (q_st[SQ_LAT] != ST_OK) begin
        index_value <= '0;
      end else if (q_big[SQ_LAT]) begin
        index_value <= '1;
      end else begin
        index_value <= root;
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_err_zero, !result_valid || status == ST_OK || index_value == '0, "error result with nonzero index")
  `ASSERT_NEXT(a_stall_hold, !adv, $stable(h_v) && $stable(g_v[DIV_LAT]), "pipeline moved while stalled")
  `ASSERT_ALWAYS(a_range_early, !a_v || a_st == ST_OK || a_st == ST_RANGE, "late status at accept stage")

endmodule

`default_nettype wire
